/* rtl/core/display_window_fill_glyph_sequencer_defines.svh */
// Assertion macros for the display window / glyph byte sequencer.
// Depends on nothing; included by dwfg_back, the only RTL file that carries checks.
`ifndef DISPLAY_WINDOW_FILL_GLYPH_SEQUENCER_DEFINES_SVH
`define DISPLAY_WINDOW_FILL_GLYPH_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DWFG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define DWFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DWFG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DWFG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/dwfg_pkg.sv */
// Shared types and constants for the display window / glyph byte sequencer.
// No dependencies; imported by every module of the block.
package dwfg_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 8;
  localparam int IDX_W         = 3;

  // Opcodes on the input channel
  localparam logic [1:0] OP_RECT  = 2'd0;
  localparam logic [1:0] OP_GLYPH = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_COL_END = 2'd0;
  localparam logic [1:0] REG_ROW_END = 2'd1;

  localparam logic [15:0] COL_END_RST = 16'd240;
  localparam logic [15:0] ROW_END_RST = 16'd319;

  // Display controller commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  typedef enum logic [1:0] {
    CK_RECT,
    CK_GLYPH,
    CK_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] x_first;
    logic [15:0] x_last;
    logic [15:0] y_first;
    logic [15:0] y_last;
    logic [15:0] dx;
    logic [15:0] dy;
    logic        nonempty;
    logic [39:0] bitmap;
    logic [15:0] fg;
    logic [15:0] bg;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       is_last;
  } res_t;

endpackage

/* rtl/core/dwfg_front.sv */
// Front end: decodes input transactions and queues them for the engine.
// Depends on dwfg_pkg.
module dwfg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode,
  input  logic [15:0]   x_start,
  input  logic [15:0]   x_stop,
  input  logic [15:0]   y_start,
  input  logic [15:0]   y_stop,
  input  logic [39:0]   glyph_bitmap,
  input  logic [15:0]   fore_color,
  input  logic [15:0]   back_color,
  output logic          cmd_valid,
  output dwfg_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import dwfg_pkg::*;

  cmd_t       entry;
  logic       entry_push;
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Classify and precompute rectangle extents; opcode 3 is dropped here.
  always_comb begin
    entry.x_first  = x_start;
    entry.y_first  = y_start;
    entry.x_last   = x_stop - 16'd1;
    entry.y_last   = y_stop - 16'd1;
    entry.dx       = x_stop - x_start;
    entry.dy       = y_stop - y_start;
    entry.nonempty = (x_stop > x_start) && (y_stop > y_start);
    entry.bitmap   = glyph_bitmap;
    entry.fg       = fore_color;
    entry.bg       = back_color;
    case (opcode)
      OP_RECT:  entry.kind = CK_RECT;
      OP_GLYPH: entry.kind = CK_GLYPH;
      default:  entry.kind = CK_TICK;
    endcase
  end

  assign full       = (count == 2'd2);
  assign entry_push = push && !full && (opcode == OP_RECT || opcode == OP_GLYPH ||
                                        opcode == OP_TICK);
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (entry_push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (entry_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, entry_push} - {1'b0, cmd_pop};
    end
  end

endmodule

/* rtl/core/dwfg_back.sv */
// Back end: runs rectangle and glyph jobs, one bus byte per tick command.
// Depends on dwfg_pkg and the assertion macro header.
`include "display_window_fill_glyph_sequencer_defines.svh"
module dwfg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  dwfg_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic [15:0]    col_end,
  input  logic [15:0]    row_end,
  input  logic           res_room,
  output logic           res_push,
  output dwfg_pkg::res_t res
);
  import dwfg_pkg::*;

  typedef enum logic [1:0] {
    J_IDLE,
    J_RECT,
    J_GLYPH
  } job_t;

  localparam logic [3:0] PH_CASET  = 4'd0;
  localparam logic [3:0] PH_RASET  = 4'd5;
  localparam logic [3:0] PH_RAMWR  = 4'd10;
  localparam logic [3:0] PH_COL_HI = 4'd11;
  localparam logic [3:0] PH_COL_LO = 4'd12;
  localparam logic [IDX_W:0] ROWS_N = (IDX_W + 1)'(GLYPH_ROWS);
  localparam logic [IDX_W:0] COLS_N = (IDX_W + 1)'(GLYPH_COLUMNS);

  job_t             job;
  logic [3:0]       phase;
  logic [15:0]      x_first;
  logic [15:0]      x_last;
  logic [15:0]      y_first;
  logic [15:0]      y_last;
  logic [31:0]      pixels_left;
  logic [IDX_W-1:0] col_idx;
  logic [IDX_W-1:0] row_idx;
  logic [39:0]      glyph_bits;
  logic [15:0]      color_fg;
  logic [15:0]      color_bg;

  logic [15:0]      xpos;
  logic [15:0]      ypos;
  logic [15:0]      color;
  logic [63:0]      bits_ext;
  logic             tick;
  logic             row_more;
  logic             col_more;
  logic             job_done;

  assign cmd_pop  = cmd_valid && res_room;
  assign tick     = cmd_pop && (cmd.kind == CK_TICK) && (job != J_IDLE);
  assign res_push = tick;
  assign bits_ext = {24'd0, glyph_bits};
  assign row_more = ({1'b0, row_idx} + 1'b1) < ROWS_N;
  assign col_more = ({1'b0, col_idx} + 1'b1) < COLS_N;

  always_comb begin
    xpos  = x_first;
    ypos  = y_first;
    color = color_fg;
    if (job == J_GLYPH) begin
      xpos  = x_first + {{(16 - IDX_W){1'b0}}, col_idx};
      ypos  = y_first + {{(16 - IDX_W){1'b0}}, row_idx};
      color = bits_ext[{col_idx, row_idx}] ? color_fg : color_bg;
    end
    res.is_data = 1'b1;
    case (phase)
      PH_CASET:  begin res.out_byte = CMD_CASET; res.is_data = 1'b0; end
      4'd1:      res.out_byte = xpos[15:8];
      4'd2:      res.out_byte = xpos[7:0];
      4'd3:      res.out_byte = x_last[15:8];
      4'd4:      res.out_byte = x_last[7:0];
      PH_RASET:  begin res.out_byte = CMD_RASET; res.is_data = 1'b0; end
      4'd6:      res.out_byte = ypos[15:8];
      4'd7:      res.out_byte = ypos[7:0];
      4'd8:      res.out_byte = y_last[15:8];
      4'd9:      res.out_byte = y_last[7:0];
      PH_RAMWR:  begin res.out_byte = CMD_RAMWR; res.is_data = 1'b0; end
      PH_COL_HI: res.out_byte = color[15:8];
      default:   res.out_byte = color[7:0];
    endcase
    // Final byte: empty-rectangle RAMWR, last pixel low byte, last glyph pixel
    if (phase < PH_RAMWR || phase == PH_COL_HI) begin
      job_done = 1'b0;
    end else if (phase == PH_RAMWR) begin
      job_done = (job == J_RECT) && (pixels_left == 32'd0);
    end else if (job == J_RECT) begin
      job_done = (pixels_left == 32'd1);
    end else begin
      job_done = !row_more && !col_more;
    end
    res.is_last = job_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job         <= J_IDLE;
      phase       <= PH_CASET;
      x_first     <= '0;
      x_last      <= '0;
      y_first     <= '0;
      y_last      <= '0;
      pixels_left <= '0;
      col_idx     <= '0;
      row_idx     <= '0;
      glyph_bits  <= '0;
      color_fg    <= '0;
      color_bg    <= '0;
    end else if (cmd_pop) begin
      case (cmd.kind)
        CK_RECT, CK_GLYPH: begin
          if (job == J_IDLE) begin
            x_first  <= cmd.x_first;
            y_first  <= cmd.y_first;
            color_fg <= cmd.fg;
            color_bg <= cmd.bg;
            col_idx  <= '0;
            row_idx  <= '0;
            phase    <= PH_CASET;
            if (cmd.kind == CK_RECT) begin
              job         <= J_RECT;
              x_last      <= cmd.x_last;
              y_last      <= cmd.y_last;
              pixels_left <= cmd.nonempty ? cmd.dx * cmd.dy : 32'd0;
              glyph_bits  <= '0;
            end else begin
              job         <= J_GLYPH;
              x_last      <= col_end;
              y_last      <= row_end;
              pixels_left <= '0;
              glyph_bits  <= cmd.bitmap;
            end
          end
        end
        CK_TICK: begin
          if (job != J_IDLE) begin
            if (job_done) begin
              job   <= J_IDLE;
              phase <= PH_CASET;
            end else if (phase < PH_RAMWR) begin
              phase <= phase + 4'd1;
            end else if (phase == PH_RAMWR) begin
              phase <= PH_COL_HI;
            end else if (phase == PH_COL_HI) begin
              phase <= PH_COL_LO;
            end else if (job == J_RECT) begin
              pixels_left <= pixels_left - 32'd1;
              phase       <= PH_COL_HI;
            end else begin
              phase <= PH_CASET;
              if (row_more) begin
                row_idx <= row_idx + 1'b1;
              end else begin
                col_idx <= col_idx + 1'b1;
                row_idx <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  `DWFG_ASSERT_IMPL(a_idle_phase, clk, rst, job == J_IDLE, phase == PH_CASET)
  `DWFG_ASSERT_IMPL(a_phase_range, clk, rst, 1'b1, phase <= PH_COL_LO)
  `DWFG_ASSERT_NEXT(a_last_idles, clk, rst, res_push && res.is_last, job == J_IDLE)
  `DWFG_ASSERT_IMPL(a_glyph_row, clk, rst, job == J_GLYPH, {1'b0, row_idx} < ROWS_N)

endmodule

/* rtl/core/dwfg_resq.sv */
// Two-entry result queue between the engine and the output ports.
// Depends on dwfg_pkg.
module dwfg_resq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  dwfg_pkg::res_t din,
  output logic           room,
  output logic           empty,
  input  logic           pop,
  output dwfg_pkg::res_t dout
);
  import dwfg_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd;

  assign room  = (count != 2'd2);
  assign empty = (count == 2'd0);
  assign rd    = pop && !empty;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* rtl/core/display_window_fill_glyph_sequencer.sv */
// Byte sequencer for an eight-bit parallel display controller.
//
// Input channel (push/full): opcode 0 loads a rectangle fill, opcode 1 loads
// a 5x8 glyph, opcode 2 is a tick that asks for the next bus byte. A start
// transaction while a job runs is dropped; a tick while idle gives nothing.
// Result channel (empty/pop): each productive tick yields one transaction of
// out_byte, is_data (0 for a command byte) and is_last (final byte of job).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// glyph column window end, index 1 the row window end; write while idle.
//
// Latency: a tick is registered in the command queue, then in the result
// queue. Throughput: one transaction per cycle on both sides, set by
// the engine, which retires one queued command per cycle if not stalled.
// Stall: if pop is held low the two-entry result queue fills, the engine
// holds, then the two-entry command queue fills and full rises.
// Reset (rst, synchronous): queues empty, job idle, window ends back to
// 240 and 319. No clearing pass; the block accepts work right after reset.
module display_window_fill_glyph_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [15:0] x_start,
  input  logic [15:0] x_stop,
  input  logic [15:0] y_start,
  input  logic [15:0] y_stop,
  input  logic [39:0] glyph_bitmap,
  input  logic [15:0] fore_color,
  input  logic [15:0] back_color,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        is_last,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dwfg_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  res_t        res_in;
  res_t        res_out;
  logic        res_push;
  logic        res_room;
  logic [15:0] col_end;
  logic [15:0] row_end;

  // Glyph window end registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_end <= COL_END_RST;
      row_end <= ROW_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COL_END: col_end <= cfg_data;
        REG_ROW_END: row_end <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: decode and queue commands
  dwfg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .x_start      (x_start),
    .x_stop       (x_stop),
    .y_start      (y_start),
    .y_stop       (y_stop),
    .glyph_bitmap (glyph_bitmap),
    .fore_color   (fore_color),
    .back_color   (back_color),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: job engine, one byte per tick
  dwfg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .col_end   (col_end),
    .row_end   (row_end),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue decouples the engine from the receiver
  dwfg_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .din   (res_in),
    .room  (res_room),
    .empty (empty),
    .pop   (pop),
    .dout  (res_out)
  );

  assign out_byte = res_out.out_byte;
  assign is_data  = res_out.is_data;
  assign is_last  = res_out.is_last;

endmodule

/* tb/bus_byte_checker.sv */
`timescale 1ns / 100ps
// Checker for the display byte sequencer: predicts the bus byte stream and
// compares every popped transaction. Depends on dwfg_pkg only.
module bus_byte_checker
  import dwfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [15:0] x_start,
  input  logic [15:0] x_stop,
  input  logic [15:0] y_start,
  input  logic [15:0] y_stop,
  input  logic [39:0] glyph_bitmap,
  input  logic [15:0] fore_color,
  input  logic [15:0] back_color,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        is_data,
  input  logic        is_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          bytes_outstanding
);

  typedef enum logic [1:0] {JOB_IDLE, JOB_FILL, JOB_GLYPH} job_t;

  // byte positions inside one window/pixel group
  localparam logic [3:0] PH_CASET    = 4'd0;
  localparam logic [3:0] PH_RAMWR    = 4'd10;
  localparam logic [3:0] PH_COLOR_HI = 4'd11;
  localparam logic [3:0] PH_COLOR_LO = 4'd12;

  job_t        job;
  logic [3:0]  phase;
  logic [15:0] win_x0, win_x1, win_y0, win_y1;
  logic [31:0] px_left;
  logic [2:0]  col_idx, row_idx;
  logic [39:0] bits;
  logic [15:0] fg, bg;
  logic [15:0] col_end, row_end;
  res_t        bytes_due[$];

  task automatic flag_mismatch(input res_t want, input res_t seen, input bit orphan);
    fail_count++;
    if (fail_count <= 10) begin
      if (orphan)
        $display("[%0t] unexpected transaction: byte=%02h data=%0b last=%0b",
                 $time, seen.out_byte, seen.is_data, seen.is_last);
      else
        $display("[%0t] mismatch: expected byte=%02h data=%0b last=%0b, got byte=%02h data=%0b last=%0b",
                 $time, want.out_byte, want.is_data, want.is_last,
                 seen.out_byte, seen.is_data, seen.is_last);
    end
  endtask

  // Advance the sequencer by one accepted input transaction.
  task automatic step_sequencer(input logic [1:0] op, input logic [15:0] xs, xe, ys, ye,
                                input logic [39:0] bmp, input logic [15:0] fc, bc);
    logic [15:0] xpos, ypos, color, w, h;
    res_t r;
    if ((op == OP_RECT || op == OP_GLYPH) && job == JOB_IDLE) begin
      win_x0  = xs;
      win_y0  = ys;
      fg      = fc;
      bg      = bc;
      col_idx = '0;
      row_idx = '0;
      phase   = PH_CASET;
      if (op == OP_RECT) begin
        job    = JOB_FILL;
        win_x1 = xe - 16'd1;   // stop of zero wraps to 0xFFFF
        win_y1 = ye - 16'd1;
        w = xe - xs;
        h = ye - ys;
        px_left = (xe > xs && ye > ys) ? {16'd0, w} * {16'd0, h} : 32'd0;
        bits = '0;
      end else begin
        job     = JOB_GLYPH;
        win_x1  = col_end;     // limits latched at job start
        win_y1  = row_end;
        px_left = '0;
        bits    = bmp;
      end
    end else if (op == OP_TICK && job != JOB_IDLE) begin
      xpos  = win_x0;
      ypos  = win_y0;
      color = fg;
      if (job == JOB_GLYPH) begin
        xpos  = win_x0 + {13'd0, col_idx};
        ypos  = win_y0 + {13'd0, row_idx};
        color = bits[{col_idx, row_idx}] ? fg : bg;
      end
      r.is_data = 1'b1;
      r.is_last = 1'b0;
      case (phase)
        4'd0:    begin r.out_byte = CMD_CASET; r.is_data = 1'b0; end
        4'd1:    r.out_byte = xpos[15:8];
        4'd2:    r.out_byte = xpos[7:0];
        4'd3:    r.out_byte = win_x1[15:8];
        4'd4:    r.out_byte = win_x1[7:0];
        4'd5:    begin r.out_byte = CMD_RASET; r.is_data = 1'b0; end
        4'd6:    r.out_byte = ypos[15:8];
        4'd7:    r.out_byte = ypos[7:0];
        4'd8:    r.out_byte = win_y1[15:8];
        4'd9:    r.out_byte = win_y1[7:0];
        4'd10:   begin r.out_byte = CMD_RAMWR; r.is_data = 1'b0; end
        4'd11:   r.out_byte = color[15:8];
        default: r.out_byte = color[7:0];
      endcase
      if (phase < PH_RAMWR) begin
        phase++;
      end else if (phase == PH_RAMWR) begin
        if (job == JOB_FILL && px_left == 0) begin
          r.is_last = 1'b1;
          job = JOB_IDLE;
          phase = PH_CASET;
        end else begin
          phase = PH_COLOR_HI;
        end
      end else if (phase == PH_COLOR_HI) begin
        phase = PH_COLOR_LO;
      end else if (job == JOB_FILL) begin
        px_left--;
        if (px_left == 0) begin
          r.is_last = 1'b1;
          job = JOB_IDLE;
          phase = PH_CASET;
        end else begin
          phase = PH_COLOR_HI;
        end
      end else begin
        phase = PH_CASET;
        if (int'(row_idx) + 1 < GLYPH_ROWS) begin
          row_idx++;
        end else if (int'(col_idx) + 1 < GLYPH_COLUMNS) begin
          col_idx++;
          row_idx = '0;
        end else begin
          r.is_last = 1'b1;
          job = JOB_IDLE;
        end
      end
      bytes_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t seen, want;
    if (rst) begin
      job     = JOB_IDLE;
      phase   = PH_CASET;
      win_x0  = '0;
      win_x1  = '0;
      win_y0  = '0;
      win_y1  = '0;
      px_left = '0;
      col_idx = '0;
      row_idx = '0;
      bits    = '0;
      fg      = '0;
      bg      = '0;
      col_end = COL_END_RST;
      row_end = ROW_END_RST;
      bytes_due.delete();
    end else begin
      // results first: a transaction pushed at this edge cannot pop here
      if (pop && !empty) begin
        seen = '{out_byte: out_byte, is_data: is_data, is_last: is_last};
        if (bytes_due.size() == 0) begin
          flag_mismatch(seen, seen, 1'b1);
        end else begin
          want = bytes_due.pop_front();
          if (seen.out_byte !== want.out_byte || seen.is_data !== want.is_data ||
              seen.is_last !== want.is_last)
            flag_mismatch(want, seen, 1'b0);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COL_END) col_end = cfg_data;
        else if (cfg_index == REG_ROW_END) row_end = cfg_data;
      end
      if (push && !full)
        step_sequencer(opcode, x_start, x_stop, y_start, y_stop, glyph_bitmap,
                       fore_color, back_color);
    end
    bytes_outstanding = bytes_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Testbench top for display_window_fill_glyph_sequencer: clock, reset,
// stimulus and verdict. Depends on dwfg_pkg, the block and bus_byte_checker.
module testbench;
  import dwfg_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;   // reserved opcode, dropped by the block
  localparam int WINDOW_BYTES      = 11;   // CASET..RAMWR
  localparam int PIXEL_GROUP_BYTES = 13;   // window plus two colour bytes
  localparam int HOLD_CYCLES       = 80;   // long receiver hold-off
  localparam int CFG_INTERVAL      = 150;  // productive items between config phases

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] xs, xe, ys, ye;
    logic [39:0] bmp;
    logic [15:0] fg, bg;
  } bus_item_t;

  typedef enum logic [1:0] {DRAIN_ALL, DRAIN_COIN, DRAIN_QUARTER, DRAIN_MOST} drain_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push, full;
  logic [1:0]  opcode;
  logic [15:0] x_start, x_stop, y_start, y_stop;
  logic [39:0] glyph_bitmap;
  logic [15:0] fore_color, back_color;
  logic        empty, pop;
  logic [7:0]  out_byte;
  logic        is_data, is_last;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int bytes_outstanding;

  // Stimulus bookkeeping: the block handles transactions strictly in order,
  // so tracking how many ticks the running job still wants is exact.
  int ticks_owed;
  int burst_left;
  bit hold_req;

  always #1 clk = ~clk;

  display_window_fill_glyph_sequencer u_top (
    .clk, .rst,
    .push, .full, .opcode, .x_start, .x_stop, .y_start, .y_stop,
    .glyph_bitmap, .fore_color, .back_color,
    .empty, .pop, .out_byte, .is_data, .is_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bus_byte_checker u_checker (
    .clk, .rst,
    .push, .full, .opcode, .x_start, .x_stop, .y_start, .y_stop,
    .glyph_bitmap, .fore_color, .back_color,
    .empty, .pop, .out_byte, .is_data, .is_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .bytes_outstanding
  );

  // Bytes a freshly loaded job produces before it goes idle.
  function automatic int stream_length(input bus_item_t it);
    if (it.opcode == OP_GLYPH)
      return GLYPH_COLUMNS * GLYPH_ROWS * PIXEL_GROUP_BYTES;
    if (it.xe > it.xs && it.ye > it.ys)
      return WINDOW_BYTES + 2 * int'(it.xe - it.xs) * int'(it.ye - it.ys);
    return WINDOW_BYTES;
  endfunction

  // Every field random, so unused fields still toggle.
  function automatic bus_item_t random_item(input logic [1:0] op);
    bus_item_t it;
    it.opcode = op;
    it.xs  = 16'($urandom);
    it.xe  = 16'($urandom);
    it.ys  = 16'($urandom);
    it.ye  = 16'($urandom);
    it.bmp = {8'($urandom), 32'($urandom)};
    it.fg  = 16'($urandom);
    it.bg  = 16'($urandom);
    return it;
  endfunction

  // Rectangle at a random origin; kept to a few pixels so jobs finish quickly.
  // Now and then the stop lands at or below the start: an empty fill.
  function automatic bus_item_t fill_job();
    bus_item_t it;
    it = random_item(OP_RECT);
    if ($urandom_range(0, 7) == 0) it.xe = 16'($urandom_range(0, it.xs));
    else                           it.xe = it.xs + 16'($urandom_range(1, 3));
    if ($urandom_range(0, 7) == 0) it.ye = 16'($urandom_range(0, it.ys));
    else                           it.ye = it.ys + 16'($urandom_range(1, 3));
    return it;
  endfunction

  // One input transaction. Called and returns at a falling edge; push is left
  // high so back-to-back items keep it asserted. Bursts of random length are
  // split by random gaps, some of them zero.
  task automatic offer(input bus_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push         <= 1'b1;
    opcode       <= it.opcode;
    x_start      <= it.xs;
    x_stop       <= it.xe;
    y_start      <= it.ys;
    y_stop       <= it.ye;
    glyph_bitmap <= it.bmp;
    fore_color   <= it.fg;
    back_color   <= it.bg;
    do @(posedge clk); while (full);
    @(negedge clk);
    if (it.opcode == OP_TICK) begin
      if (ticks_owed > 0) ticks_owed--;
    end else if ((it.opcode == OP_RECT || it.opcode == OP_GLYPH) && ticks_owed == 0) begin
      ticks_owed = stream_length(it);
    end
  endtask

  // Leaves cfg_valid high so that back-to-back writes keep it asserted.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Quiesce the input side, let every predicted byte drain, allow for ticks
  // still in the pipeline that give no byte, then rewrite both end limits.
  // A glyph job may still be loaded: its limits must stay as latched.
  task automatic write_limits(input logic [15:0] col_end, input logic [15:0] row_end);
    push <= 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_COL_END, col_end);
    write_reg(REG_ROW_END, row_end);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver: one long hold-off once the stimulus asks for it, otherwise
  // stall patterns drawn at random from the drain modes.
  initial begin : receiver
    int          held;
    int          mode_left;
    int          beat;
    drain_mode_t mode;
    pop       = 1'b0;
    held      = 0;
    mode_left = 0;
    beat      = 0;
    mode      = DRAIN_ALL;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        held++;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        beat++;
        case (mode)
          DRAIN_ALL:     pop <= 1'b1;
          DRAIN_COIN:    pop <= ($urandom_range(0, 1) == 1);
          DRAIN_QUARTER: pop <= (beat % 4 == 0);
          default:       pop <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    bus_item_t   it;
    int          productive;
    int          next_cfg_at;
    int          cfg_phase;
    int          glyph_jobs;
    int          roll;
    logic [39:0] last_bmp;

    rst          = 1'b1;
    push         = 1'b0;
    opcode       = OP_TICK;
    x_start      = '0;
    x_stop       = '0;
    y_start      = '0;
    y_stop       = '0;
    glyph_bitmap = '0;
    fore_color   = '0;
    back_color   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_COL_END;
    cfg_data     = '0;
    hold_req     = 1'b0;
    ticks_owed   = 0;
    burst_left   = 0;
    productive   = 0;
    next_cfg_at  = CFG_INTERVAL;
    cfg_phase    = 0;
    glyph_jobs   = 0;
    last_bmp     = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Limits at opposite extremes for the directed glyph.
    write_limits(16'hFFFF, 16'h0000);

    // --- directed part ---
    offer(random_item(OP_TICK));   // tick with no job: no byte
    offer(random_item(OP_NONE));   // reserved opcode: ignored

    // Stop of zero below a start of 0xFFFF: window ends wrap, no pixels,
    // RAMWR is the last byte.
    it = random_item(OP_RECT);
    it.xs = 16'hFFFF;
    it.xe = 16'h0000;
    it.ys = 16'h0000;
    it.ye = 16'h0000;
    offer(it);
    while (ticks_owed > 0) offer(random_item(OP_TICK));

    // Single pixel in the far corner, all-ones colour; a glyph start while
    // the fill runs must be dropped.
    it = random_item(OP_RECT);
    it.xs = 16'hFFFE;
    it.xe = 16'hFFFF;
    it.ys = 16'hFFFE;
    it.ye = 16'hFFFF;
    it.fg = 16'hFFFF;
    offer(it);
    offer(random_item(OP_GLYPH));
    while (ticks_owed > 0) offer(random_item(OP_TICK));

    // Glyph near the top of the coordinate range so column and row wrap;
    // every bit set selects the foreground. Its ticks run in the random part.
    it = random_item(OP_GLYPH);
    it.xs  = 16'hFFFD;
    it.ys  = 16'hFFFB;
    it.bmp = '1;
    it.fg  = 16'hFFFF;
    it.bg  = 16'h0000;
    offer(it);

    // --- random part ---
    // Mostly well-formed jobs (start, then exactly the ticks it needs) with
    // some noise: starts while busy, reserved opcodes, ticks while idle.
    hold_req = 1'b1;   // receiver stalls long while the glyph keeps ticking
    while (productive < 400 || ticks_owed > 0) begin
      if (productive >= next_cfg_at) begin
        next_cfg_at += CFG_INTERVAL;
        cfg_phase++;
        case (cfg_phase % 4)
          0:       write_limits(16'hFFFF, 16'hFFFF);
          1:       write_limits(16'h0000, 16'hFFFF);
          2:       write_limits(16'($urandom), 16'($urandom));
          default: write_limits(COL_END_RST, ROW_END_RST);
        endcase
      end
      if (ticks_owed > 0) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          offer(random_item($urandom_range(0, 1) ? OP_GLYPH : OP_RECT));
        end else if (roll == 1) begin
          offer(random_item(OP_NONE));
        end else begin
          offer(random_item(OP_TICK));
          productive++;
        end
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
          if ($urandom_range(0, 4) == 0) begin
            // Alternate a random bitmap with its complement so every bit
            // selects both colours.
            it = random_item(OP_GLYPH);
            if (glyph_jobs % 2 == 1) it.bmp = ~last_bmp;
            last_bmp = it.bmp;
            glyph_jobs++;
          end else begin
            it = fill_job();
          end
          offer(it);
          productive++;
        end else if (roll == 8) begin
          offer(random_item(OP_TICK));
        end else begin
          offer(random_item(OP_NONE));
        end
      end
    end

    // Drain, then keep watching so that any stray byte in the pipeline shows.
    push <= 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* display_window_fill_glyph_sequencer.f */
+incdir+rtl/core
rtl/core/dwfg_pkg.sv
rtl/core/dwfg_front.sv
rtl/core/dwfg_back.sv
rtl/core/dwfg_resq.sv
rtl/core/display_window_fill_glyph_sequencer.sv
tb/bus_byte_checker.sv
tb/testbench.sv
